[rtl/vmsd_pkg.sv]
`timescale 1ns / 1ps

package vmsd_pkg;

    // Fixed field widths.
    localparam int BYTE_W = 8;
    localparam int SIZE_W = 12;
    localparam int OUT_W  = 19;

    // Pen position after reset, in pixels before scaling.
    localparam int PEN_RESET = -32700;

    // Scaling divides x by 2048 and y by 1024.
    localparam int X_SHIFT = 11;
    localparam int Y_SHIFT = 10;
    localparam int X_ROUND = (1 << X_SHIFT) - 1;
    localparam int Y_ROUND = (1 << Y_SHIFT) - 1;

    // Sizes after reset.
    localparam logic [SIZE_W-1:0] X_SIZE_RESET = 12'd512;
    localparam logic [SIZE_W-1:0] Y_SIZE_RESET = 12'd256;

    // Configuration register indexes.
    localparam logic CFG_X_SIZE = 1'b0;
    localparam logic CFG_Y_SIZE = 1'b1;

    // Top two bits of a command byte.
    localparam logic [1:0] OP_UNIT_PAIR = 2'b00;
    localparam logic [1:0] OP_OFFSET    = 2'b01;
    localparam logic [1:0] OP_UNIT      = 2'b10;
    localparam logic [1:0] OP_EXTENDED  = 2'b11;

    // Extended commands, kept by their low two bits.
    localparam logic [1:0] CMD_LONG_MOVE = 2'd0;
    localparam logic [1:0] CMD_LONG_DRAW = 2'd1;
    localparam logic [1:0] CMD_MED_DRAW  = 2'd2;
    localparam logic [1:0] CMD_MED_MOVE  = 2'd3;

    // Operand byte counts of the extended commands.
    localparam logic [2:0] LONG_OPS = 3'd4;
    localparam logic [2:0] MED_OPS  = 3'd2;

    // Number of segments that one byte produces.
    localparam logic [1:0] SEG_NONE = 2'd0;
    localparam logic [1:0] SEG_ONE  = 2'd1;
    localparam logic [1:0] SEG_TWO  = 2'd2;

    // Unit steps for direction codes 0..7, two's complement in two bits.
    localparam logic [1:0] DIR_DX [8] = '{2'b11, 2'b00, 2'b01, 2'b11,
                                          2'b01, 2'b11, 2'b00, 2'b01};
    localparam logic [1:0] DIR_DY [8] = '{2'b11, 2'b11, 2'b11, 2'b00,
                                          2'b00, 2'b01, 2'b01, 2'b01};

endpackage

[rtl/vmsd_decode.sv]
`timescale 1ns / 1ps

module vmsd_decode #(
    parameter int COORD_WIDTH = 18
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [vmsd_pkg::BYTE_W-1:0]   i_byte,
    output logic [COORD_WIDTH-1:0]        o_px [3],
    output logic [COORD_WIDTH-1:0]        o_py [3],
    output logic [1:0]                    o_count
);
    import vmsd_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam logic [CW-1:0] PEN_INIT = CW'(PEN_RESET);

    logic [CW-1:0] r_pen_x, n_pen_x;
    logic [CW-1:0] r_pen_y, n_pen_y;
    logic [1:0]    r_pend_cmd, n_pend_cmd;
    logic [2:0]    r_ops_left, n_ops_left;
    logic [23:0]   r_gather, n_gather;

    logic [31:0]   gath;
    logic [2:0]    left_dec;
    logic [1:0]    dxa, dya, dxb, dyb;
    logic [CW-1:0] ux1, uy1, ux2, uy2;
    logic [7:0]    mdx, mdy;
    logic [2:0]    odx, ody;
    logic [CW-1:0] nx, ny;

    assign gath     = {r_gather, i_byte};
    assign left_dec = r_ops_left - 3'd1;
    assign dxa      = DIR_DX[i_byte[5:3]];
    assign dya      = DIR_DY[i_byte[5:3]];
    assign dxb      = DIR_DX[i_byte[2:0]];
    assign dyb      = DIR_DY[i_byte[2:0]];
    assign ux1      = r_pen_x + {{(CW-2){dxa[1]}}, dxa};
    assign uy1      = r_pen_y + {{(CW-2){dya[1]}}, dya};
    assign ux2      = ux1 + {{(CW-2){dxb[1]}}, dxb};
    assign uy2      = uy1 + {{(CW-2){dyb[1]}}, dyb};

    // Medium operands are biased by 128: flipping the top bit gives the signed step.
    assign mdx = {~gath[15], gath[14:8]};
    assign mdy = {~gath[7], gath[6:0]};
    // Offset draws are biased by 4 in the same way.
    assign odx = {~i_byte[5], i_byte[4:3]};
    assign ody = {~i_byte[2], i_byte[1:0]};

    always_comb begin
        if (r_pend_cmd inside {CMD_LONG_MOVE, CMD_LONG_DRAW}) begin
            nx = CW'(gath[31:16]);
            ny = CW'(gath[15:0]);
        end else begin
            nx = r_pen_x + {{(CW-8){mdx[7]}}, mdx};
            ny = r_pen_y + {{(CW-8){mdy[7]}}, mdy};
        end
    end

    always_comb begin
        n_pen_x    = r_pen_x;
        n_pen_y    = r_pen_y;
        n_pend_cmd = r_pend_cmd;
        n_ops_left = r_ops_left;
        n_gather   = r_gather;
        o_px[0]    = r_pen_x;
        o_py[0]    = r_pen_y;
        o_px[1]    = ux1;
        o_py[1]    = uy1;
        o_px[2]    = ux2;
        o_py[2]    = uy2;
        o_count    = SEG_NONE;
        if (r_ops_left != 3'd0) begin
            n_gather   = gath[23:0];
            n_ops_left = left_dec;
            if (left_dec == 3'd0) begin
                n_pen_x = nx;
                n_pen_y = ny;
                o_px[1] = nx;
                o_py[1] = ny;
                if (r_pend_cmd inside {CMD_LONG_DRAW, CMD_MED_DRAW}) begin
                    o_count = SEG_ONE;
                end
            end
        end else begin
            case (i_byte[7:6])
                OP_UNIT_PAIR: begin
                    n_pen_x = ux2;
                    n_pen_y = uy2;
                    o_count = SEG_TWO;
                end
                OP_OFFSET: begin
                    o_px[1] = r_pen_x + {{(CW-3){odx[2]}}, odx};
                    o_py[1] = r_pen_y + {{(CW-3){ody[2]}}, ody};
                    n_pen_x = o_px[1];
                    n_pen_y = o_py[1];
                    o_count = SEG_ONE;
                end
                OP_UNIT: begin
                    n_pen_x = ux1;
                    n_pen_y = uy1;
                    o_count = SEG_ONE;
                end
                OP_EXTENDED: begin
                    if (i_byte[5:2] == 4'd0) begin
                        n_pend_cmd = i_byte[1:0];
                        if (i_byte[1:0] inside {CMD_LONG_MOVE, CMD_LONG_DRAW}) begin
                            n_ops_left = LONG_OPS;
                        end else begin
                            n_ops_left = MED_OPS;
                        end
                    end
                end
                default: begin
                    o_count = SEG_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x    <= PEN_INIT;
            r_pen_y    <= PEN_INIT;
            r_pend_cmd <= CMD_LONG_MOVE;
            r_ops_left <= 3'd0;
        end else if (i_step) begin
            r_pen_x    <= n_pen_x;
            r_pen_y    <= n_pen_y;
            r_pend_cmd <= n_pend_cmd;
            r_ops_left <= n_ops_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_gather <= n_gather;
        end
    end

endmodule

[rtl/vmsd_scale.sv]
`timescale 1ns / 1ps

module vmsd_scale #(
    parameter int COORD_WIDTH = 18
) (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [vmsd_pkg::SIZE_W-1:0]   i_x_size,
    input  logic [vmsd_pkg::SIZE_W-1:0]   i_y_size,
    input  logic [COORD_WIDTH-1:0]        i_px [3],
    input  logic [COORD_WIDTH-1:0]        i_py [3],
    output logic [vmsd_pkg::OUT_W-1:0]    o_sx [3],
    output logic [vmsd_pkg::OUT_W-1:0]    o_sy [3]
);
    import vmsd_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int PW = CW + SIZE_W + 1;

    logic [OUT_W-1:0] n_sx [3];
    logic [OUT_W-1:0] n_sy [3];
    logic [OUT_W-1:0] r_sx [3];
    logic [OUT_W-1:0] r_sy [3];

    // Each point: signed coordinate times unsigned size, then a shift that
    // truncates toward zero (negative products are biased up before the shift).
    for (genvar i = 0; i < 3; i++) begin : g_pt
        logic signed [PW-1:0] prod_x, prod_y;
        logic [PW-1:0]        adj_x, adj_y;

        assign prod_x = $signed(i_px[i]) * $signed({1'b0, i_x_size});
        assign prod_y = $signed(i_py[i]) * $signed({1'b0, i_y_size});
        assign adj_x  = prod_x + (prod_x[PW-1] ? PW'(X_ROUND) : {PW{1'b0}});
        assign adj_y  = prod_y + (prod_y[PW-1] ? PW'(Y_ROUND) : {PW{1'b0}});
        assign n_sx[i] = adj_x[X_SHIFT+OUT_W-1:X_SHIFT];
        assign n_sy[i] = adj_y[Y_SHIFT+OUT_W-1:Y_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sx <= n_sx;
            r_sy <= n_sy;
        end
    end

    assign o_sx = r_sx;
    assign o_sy = r_sy;

endmodule

[rtl/vector_map_stream_decoder.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// map       in         i_map_valid / o_map_stall  i_map_byte
// seg       out        o_seg_valid / i_seg_stall  o_from_x o_from_y o_to_x o_to_y
//                                                 o_last_of_run
// cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index i_cfg_data
//
// A byte is taken every cycle unless o_map_stall is high; a double unit-draw
// byte holds the result stage until both of its segments are taken, so the
// single result port bounds the worst case. Results leave from stage 2.
// Reset puts the pen at -32700 in both axes, the sizes at 512 and 256, and
// drops any pending command; there is no clearing pass.
// A stall on the seg channel backs up through the pipeline into o_map_stall.

module vector_map_stream_decoder #(
    parameter int COORD_WIDTH = 18
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_map_valid,
    output logic                                o_map_stall,
    input  logic [vmsd_pkg::BYTE_W-1:0]         i_map_byte,

    output logic                                o_seg_valid,
    input  logic                                i_seg_stall,
    output logic signed [vmsd_pkg::OUT_W-1:0]   o_from_x,
    output logic signed [vmsd_pkg::OUT_W-1:0]   o_from_y,
    output logic signed [vmsd_pkg::OUT_W-1:0]   o_to_x,
    output logic signed [vmsd_pkg::OUT_W-1:0]   o_to_y,
    output logic                                o_last_of_run,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [vmsd_pkg::SIZE_W-1:0]         i_cfg_data
);
    import vmsd_pkg::*;

    localparam int CW = COORD_WIDTH;

    // Configuration registers. The user must issue writes only while the block is
    // idle; the block itself does not enforce this. Writes are always accepted.
    logic [SIZE_W-1:0] r_x_size;
    logic [SIZE_W-1:0] r_y_size;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_size <= X_SIZE_RESET;
            r_y_size <= Y_SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_X_SIZE: r_x_size <= i_cfg_data;
                CFG_Y_SIZE: r_y_size <= i_cfg_data;
                default:    r_x_size <= r_x_size;
            endcase
        end
    end

    // Stage 0 holds the accepted byte, stage 1 the decoded endpoints, stage 2
    // the scaled endpoints that feed the result port.
    logic              r_s0_vld;
    logic [BYTE_W-1:0] r_s0_byte;
    logic              r_s1_vld;
    logic [1:0]        r_s1_cnt;
    logic [CW-1:0]     r_s1_px [3];
    logic [CW-1:0]     r_s1_py [3];
    logic              r_s2_vld;
    logic              r_s2_two;
    logic              r_s2_sel;

    logic [CW-1:0]     dec_px [3];
    logic [CW-1:0]     dec_py [3];
    logic [1:0]        dec_cnt;
    logic [OUT_W-1:0]  sc_x [3];
    logic [OUT_W-1:0]  sc_y [3];

    logic in_acc, out_acc;
    logic s2_done, s2_free, s2_load;
    logic s1_adv, s1_free, s0_adv;

    // Ready flows backward: a stage frees up when its content moves on.
    assign out_acc     = o_seg_valid && !i_seg_stall;
    assign s2_done     = out_acc && (!r_s2_two || r_s2_sel);
    assign s2_free     = !r_s2_vld || s2_done;
    assign s1_adv      = r_s1_vld && ((r_s1_cnt == SEG_NONE) || s2_free);
    assign s2_load     = s1_adv && (r_s1_cnt != SEG_NONE);
    assign s1_free     = !r_s1_vld || s1_adv;
    assign s0_adv      = r_s0_vld && s1_free;
    assign o_map_stall = r_s0_vld && !s1_free;
    assign in_acc      = i_map_valid && !o_map_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (in_acc) begin
            r_s0_vld <= 1'b1;
        end else if (s0_adv) begin
            r_s0_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s0_byte <= i_map_byte;
        end
    end

    // The decoder advances its pen and operand state only when the byte it
    // sees actually moves into stage 1.
    vmsd_decode #(
        .COORD_WIDTH (CW)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s0_adv),
        .i_byte  (r_s0_byte),
        .o_px    (dec_px),
        .o_py    (dec_py),
        .o_count (dec_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s0_adv) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_adv) begin
            r_s1_cnt <= dec_cnt;
            r_s1_px  <= dec_px;
            r_s1_py  <= dec_py;
        end
    end

    // Bytes that produce no segment are dropped at stage 1; the others
    // have their endpoints scaled into stage 2.
    vmsd_scale #(
        .COORD_WIDTH (CW)
    ) u_scale (
        .i_clk    (i_clk),
        .i_load   (s2_load),
        .i_x_size (r_x_size),
        .i_y_size (r_y_size),
        .i_px     (r_s1_px),
        .i_py     (r_s1_py),
        .o_sx     (sc_x),
        .o_sy     (sc_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_s2_sel <= 1'b0;
        end else if (s2_load) begin
            r_s2_vld <= 1'b1;
            r_s2_sel <= 1'b0;
        end else if (s2_done) begin
            r_s2_vld <= 1'b0;
            r_s2_sel <= 1'b0;
        end else if (out_acc) begin
            r_s2_sel <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_s2_two <= (r_s1_cnt == SEG_TWO);
        end
    end

    // A double draw shares its middle point: the first transaction runs from
    // point 0 to point 1, the second from point 1 to point 2.
    assign o_seg_valid   = r_s2_vld;
    assign o_from_x      = r_s2_sel ? sc_x[1] : sc_x[0];
    assign o_from_y      = r_s2_sel ? sc_y[1] : sc_y[0];
    assign o_to_x        = r_s2_sel ? sc_x[2] : sc_x[1];
    assign o_to_y        = r_s2_sel ? sc_y[2] : sc_y[1];
    assign o_last_of_run = r_s2_sel || !r_s2_two;

    a_sel_only_in_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_sel |-> (r_s2_vld && r_s2_two))
        else $error("second segment selected outside a double draw");

    a_pair_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_s2_two && !r_s2_sel) |=> (o_seg_valid && o_last_of_run))
        else $error("second segment of a double draw missing");

    a_stall_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_map_stall |-> (r_s0_vld && r_s1_vld))
        else $error("input stalled with room in the pipeline");

endmodule
